/* sv/tclt_pkg.sv */
// Package: shared constants, payload structs and control types for the connect tracker.
`timescale 1ns / 1ps
package tclt_pkg;

  localparam int CONN_ENTRIES   = 1024;
  localparam int WORKER_ENTRIES = 512;

  localparam int CIDX_W = $clog2(CONN_ENTRIES);
  localparam int WIDX_W = (WORKER_ENTRIES > 1) ? $clog2(WORKER_ENTRIES) : 1;
  localparam int SIDX_W = (CIDX_W > WIDX_W) ? CIDX_W : WIDX_W;
  localparam int CLR_N  = (CONN_ENTRIES > WORKER_ENTRIES) ? CONN_ENTRIES : WORKER_ENTRIES;
  localparam int CLR_W  = $clog2(CLR_N);

  localparam logic [1:0] CMD_STATE  = 2'd0;
  localparam logic [1:0] CMD_RETX   = 2'd1;
  localparam logic [1:0] CMD_ADD    = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  localparam logic [3:0] ST_ESTABLISHED = 4'd1;
  localparam logic [3:0] ST_SYN_TX      = 4'd2;
  localparam logic [3:0] ST_FIN_WAIT1   = 4'd4;
  localparam logic [3:0] ST_FIN_WAIT2   = 4'd5;
  localparam logic [3:0] ST_TIME_WAIT   = 4'd6;
  localparam logic [3:0] ST_CLOSE       = 4'd7;
  localparam logic [3:0] ST_CLOSE_WAIT  = 4'd8;
  localparam logic [3:0] ST_LAST_ACK    = 4'd9;
  localparam logic [3:0] ST_CLOSING     = 4'd11;

  localparam logic [15:0] FAMILY_IPV4 = 16'd2;
  localparam logic [15:0] PROTO_TCP   = 16'd6;
  localparam logic [7:0]  RETX_MAX    = 8'd255;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] sock_key;
    logic [3:0]  old_state;
    logic [3:0]  new_state;
    logic [15:0] addr_family;
    logic [15:0] proto_number;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic [22:0] task_id;
    logic [63:0] now_ns;
  } in_t;

  typedef struct packed {
    logic [63:0] start_ns;
    logic [63:0] lat_ns;
    logic [31:0] out_addr;
    logic [15:0] out_port;
    logic        failed;
    logic [7:0]  retx_count;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [63:0] start;
    logic [31:0] addr;
    logic [7:0]  retx;
  } conn_ent_t;

  typedef struct packed {
    logic        valid;
    logic [22:0] id;
  } wrk_ent_t;

  typedef enum logic [2:0] {
    K_NONE, K_RETX, K_ADD, K_REMOVE, K_SYN, K_CLOSE, K_TEAR
  } kind_t;

  typedef struct packed {
    logic load_in;
    logic wscan_start;
    logic cscan_start;
    logic wr_worker;
    logic wr_conn;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic  clear_busy;
    logic  scan_busy;
    logic  hit;
    logic  free;
    logic  out_free;
    kind_t kind;
  } ctl_sts_t;

endpackage

/* sv/tclt_dp.sv */
// Datapath: tables, linear scan engine, clearing pass and output word register.
`timescale 1ns / 1ps
module tclt_dp import tclt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_t      in_data,
  input  ctl_cmd_t cmd,
  output ctl_sts_t sts,
  output logic     out_valid,
  input  logic     out_ready,
  output out_t     out_data
);

  conn_ent_t conn_mem [0:CONN_ENTRIES-1];
  wrk_ent_t  wrk_mem  [0:WORKER_ENTRIES-1];

  in_t              in_r;
  logic             clr_act_r;
  logic [CLR_W-1:0] clr_cnt_r;
  logic             scan_act_r, scan_sel_r, chk_r;
  logic [SIDX_W-1:0] scan_cnt_r, chk_idx_r, hit_idx_r, free_idx_r;
  logic             hit_r, free_r;
  conn_ent_t        hit_ent_r, conn_rd_r;
  wrk_ent_t         wrk_rd_r;
  logic             out_valid_r;
  out_t             out_r;

  kind_t            kind;
  logic [SIDX_W-1:0] scan_last;
  logic             c_we, w_we, clr_c, clr_w;
  logic [SIDX_W-1:0] c_sel_idx;
  logic [CIDX_W-1:0] c_waddr;
  logic [WIDX_W-1:0] w_waddr, w_raddr;
  logic [CIDX_W-1:0] c_raddr;
  conn_ent_t        c_wdata;
  wrk_ent_t         w_wdata;
  logic             match;

  always_comb begin
    kind = K_NONE;
    unique case (in_r.cmd)
      CMD_RETX:   kind = K_RETX;
      CMD_ADD:    kind = K_ADD;
      CMD_REMOVE: kind = K_REMOVE;
      default: begin
        if (in_r.addr_family == FAMILY_IPV4 && in_r.proto_number == PROTO_TCP) begin
          case (in_r.new_state) inside
            ST_SYN_TX:                           kind = K_SYN;
            ST_ESTABLISHED, ST_CLOSE:            kind = K_CLOSE;
            ST_FIN_WAIT1, ST_FIN_WAIT2, ST_TIME_WAIT,
            ST_CLOSE_WAIT, ST_LAST_ACK, ST_CLOSING: kind = K_TEAR;
            default:                             kind = K_NONE;
          endcase
        end
      end
    endcase
  end

  assign clr_c = clr_act_r && ({1'b0, clr_cnt_r} < (CLR_W+1)'(CONN_ENTRIES));
  assign clr_w = clr_act_r && ({1'b0, clr_cnt_r} < (CLR_W+1)'(WORKER_ENTRIES));
  assign c_we  = clr_c || cmd.wr_conn;
  assign w_we  = clr_w || cmd.wr_worker;

  // insert goes to the matching entry, else to the first free one
  assign c_sel_idx = (kind == K_SYN && !hit_r) ? free_idx_r : hit_idx_r;

  always_comb begin
    c_waddr = clr_act_r ? clr_cnt_r[CIDX_W-1:0] : c_sel_idx[CIDX_W-1:0];
    w_waddr = clr_act_r ? clr_cnt_r[WIDX_W-1:0]
                        : ((kind == K_ADD) ? free_idx_r[WIDX_W-1:0] : hit_idx_r[WIDX_W-1:0]);
    c_wdata = hit_ent_r;
    w_wdata = '0;
    if (clr_act_r) begin
      c_wdata = '0;
    end else begin
      w_wdata.valid = (kind == K_ADD);
      w_wdata.id    = in_r.task_id;
      case (kind)
        K_SYN: begin
          c_wdata.valid = 1'b1;
          c_wdata.key   = in_r.sock_key;
          c_wdata.start = in_r.now_ns;
          c_wdata.addr  = in_r.dest_addr;
          c_wdata.retx  = '0;
        end
        K_RETX: begin
          if (hit_ent_r.retx != RETX_MAX) c_wdata.retx = hit_ent_r.retx + 8'd1;
        end
        default: c_wdata.valid = 1'b0;
      endcase
    end
  end

  assign c_raddr = scan_cnt_r[CIDX_W-1:0];
  assign w_raddr = scan_cnt_r[WIDX_W-1:0];

  always_ff @(posedge clk) begin
    if (c_we) conn_mem[c_waddr] <= c_wdata;
    conn_rd_r <= conn_mem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (w_we) wrk_mem[w_waddr] <= w_wdata;
    wrk_rd_r <= wrk_mem[w_raddr];
  end

  assign scan_last = scan_sel_r ? SIDX_W'(CONN_ENTRIES - 1) : SIDX_W'(WORKER_ENTRIES - 1);
  assign match = scan_sel_r ? (conn_rd_r.valid && conn_rd_r.key == in_r.sock_key)
                            : (wrk_rd_r.valid && wrk_rd_r.id == in_r.task_id);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r   <= 1'b1;
      clr_cnt_r   <= '0;
      scan_act_r  <= 1'b0;
      chk_r       <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_act_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_W'(CLR_N - 1)) clr_act_r <= 1'b0;
      end
      chk_r <= scan_act_r;
      if (cmd.wscan_start || cmd.cscan_start) begin
        scan_act_r <= 1'b1;
        hit_r      <= 1'b0;
        free_r     <= 1'b0;
      end else begin
        if (scan_act_r && scan_cnt_r == scan_last) scan_act_r <= 1'b0;
        if (chk_r) begin
          if (match && !hit_r) hit_r <= 1'b1;
          if (!(scan_sel_r ? conn_rd_r.valid : wrk_rd_r.valid) && !free_r) free_r <= 1'b1;
        end
      end
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_data;
    if (cmd.wscan_start || cmd.cscan_start) begin
      scan_cnt_r <= '0;
      scan_sel_r <= cmd.cscan_start;
    end else if (scan_act_r) begin
      scan_cnt_r <= scan_cnt_r + 1'b1;
    end
    chk_idx_r <= scan_cnt_r;
    if (chk_r && !cmd.wscan_start && !cmd.cscan_start) begin
      if (match && !hit_r) begin
        hit_idx_r <= chk_idx_r;
        hit_ent_r <= conn_rd_r;
      end
      if (!(scan_sel_r ? conn_rd_r.valid : wrk_rd_r.valid) && !free_r) free_idx_r <= chk_idx_r;
    end
    if (cmd.load_out) begin
      out_r.start_ns   <= hit_ent_r.start;
      out_r.lat_ns     <= in_r.now_ns - hit_ent_r.start;
      out_r.out_addr   <= hit_ent_r.addr;
      out_r.out_port   <= in_r.dest_port;
      out_r.failed     <= (in_r.old_state == ST_SYN_TX) && (in_r.new_state == ST_CLOSE);
      out_r.retx_count <= hit_ent_r.retx;
    end
  end

  assign sts.clear_busy = clr_act_r;
  assign sts.scan_busy  = scan_act_r || chk_r;
  assign sts.hit        = hit_r;
  assign sts.free       = free_r;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.kind       = kind;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* sv/tclt_ctrl.sv */
// Controller: sequences decode, table scans, table updates and result hand-off.
`timescale 1ns / 1ps
module tclt_ctrl import tclt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DEC   = 6'b000100,
    S_WSCAN = 6'b001000,
    S_CSCAN = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: if (!sts.clear_busy) state_nxt = S_IDLE;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.kind)
          K_ADD, K_REMOVE, K_SYN: begin
            cmd.wscan_start = 1'b1;
            state_nxt       = S_WSCAN;
          end
          K_RETX, K_CLOSE, K_TEAR: begin
            cmd.cscan_start = 1'b1;
            state_nxt       = S_CSCAN;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_WSCAN: begin
        if (!sts.scan_busy) begin
          state_nxt = S_IDLE;
          case (sts.kind)
            K_ADD:    cmd.wr_worker = !sts.hit && sts.free;
            K_REMOVE: cmd.wr_worker = sts.hit;
            default: begin
              if (sts.hit) begin
                cmd.cscan_start = 1'b1;
                state_nxt       = S_CSCAN;
              end
            end
          endcase
        end
      end
      S_CSCAN: begin
        if (!sts.scan_busy) begin
          state_nxt = S_IDLE;
          case (sts.kind)
            K_SYN:   cmd.wr_conn = sts.hit || sts.free;
            K_CLOSE: if (sts.hit) state_nxt = S_EMIT;
            default: cmd.wr_conn = sts.hit;
          endcase
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.wr_conn  = 1'b1;
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

/* sv/tcp_connect_latency_tracker_top.sv */
// Every table lookup is a linear scan, one entry per cycle, read data registered.
// Worker commands scan the worker table; retransmit, teardown and close events scan the
// connection table (a close that hits also loads a result); a connect-start scans both,
// the connection table only if its task is found. One word at a time; a result waits in
// the output register while the next word is taken, a second result waits for it to drain.
// Reset (rst_n low, synchronous) clears both tables; in_ready stays low until the clear ends.
`timescale 1ns / 1ps
module tcp_connect_latency_tracker_top import tclt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  tclt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tclt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
